@@ hw/rtl/sfd_pkg.sv @@
// Shared types and constants for the sensor packet deframer.
// Used by every deframer module; no dependencies.
package sfd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned MAXF_W     = 10;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned FIFO_DEPTH = 4;

  // Whole frame = sync pair + 4 address bytes + id + 2 length bytes + declared length
  localparam int unsigned FRAME_OVERHEAD = 9;

  localparam logic [MAXF_W-1:0] MAX_FRAME_RST   = MAXF_W'(350);
  localparam logic [7:0]        SYNC_FIRST_RST  = 8'hEF;
  localparam logic [7:0]        SYNC_SECOND_RST = 8'h01;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd2;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSUM  = 2'd1;
  localparam logic [1:0] ST_BADLEN  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HEADER,
    PH_DATA,
    PH_CHECK
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic [1:0] status;
  } result_t;

endpackage

@@ hw/rtl/sfd_if.sv @@
// Valid/ready channel interfaces for the deframer input bytes and results.
// Depends on nothing but plain logic types.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, output data_byte, output frame_end, output status,
                  input ready);
  modport sink   (input valid, input data_byte, input frame_end, input status,
                  output ready);
endinterface

@@ hw/rtl/sfd_front.sv @@
// Front end: configuration registers and the frame parser state machine.
// Depends on sfd_pkg and sfd_in_if; pushes result beats into the queue.
module sfd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sfd_in_if.sink                            in_ch,
  input  logic                              full_i,
  output logic                              push_o,
  output sfd_pkg::result_t                  push_data_o
);

  localparam logic [sfd_pkg::IDX_W-1:0] HDR_ID_IDX  = sfd_pkg::IDX_W'(4);
  localparam logic [sfd_pkg::IDX_W-1:0] HDR_LHI_IDX = sfd_pkg::IDX_W'(5);
  localparam logic [sfd_pkg::IDX_W-1:0] HDR_LLO_IDX = sfd_pkg::IDX_W'(6);

  logic [sfd_pkg::MAXF_W-1:0] max_frame_q;
  logic [7:0]                 sync_first_q, sync_second_q;

  sfd_pkg::phase_e            phase_q, phase_d;
  logic [sfd_pkg::IDX_W-1:0]  idx_q, idx_d, idx_inc;
  logic [sfd_pkg::IDX_W-1:0]  cnt_q, cnt_d;
  logic [7:0]                 len_hi_q, len_hi_d;
  logic [7:0]                 csum_hi_q, csum_hi_d;
  logic [sfd_pkg::SUM_W-1:0]  sum_q, sum_d, sum_add;
  logic [15:0]                len_full;
  logic                       len_bad;
  logic                       acc;
  logic [7:0]                 b;

  assign in_ch.ready = !full_i;
  assign acc         = in_ch.valid && !full_i;
  assign b           = in_ch.rx_byte;
  assign idx_inc     = idx_q + sfd_pkg::IDX_W'(1);
  assign sum_add     = sum_q + sfd_pkg::SUM_W'(b);
  assign len_full    = {len_hi_q, b};
  assign len_bad     = (len_full < 16'd2) ||
                       (({1'b0, len_full} + 17'(sfd_pkg::FRAME_OVERHEAD)) >
                        17'(max_frame_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q   <= sfd_pkg::MAX_FRAME_RST;
      sync_first_q  <= sfd_pkg::SYNC_FIRST_RST;
      sync_second_q <= sfd_pkg::SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfd_pkg::CFG_MAX_FRAME:   max_frame_q   <= cfg_data_i[sfd_pkg::MAXF_W-1:0];
        sfd_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i[7:0];
        sfd_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sfd_pkg::PH_HUNT1;
      idx_q     <= '0;
      cnt_q     <= '0;
      len_hi_q  <= '0;
      csum_hi_q <= '0;
      sum_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      len_hi_q  <= len_hi_d;
      csum_hi_q <= csum_hi_d;
      sum_q     <= sum_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    len_hi_d    = len_hi_q;
    csum_hi_d   = csum_hi_q;
    sum_d       = sum_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (acc) begin
      if (in_ch.opcode == sfd_pkg::OP_TIMEOUT) begin
        // silence inside a frame closes it; while hunting just restart
        if (phase_q inside {sfd_pkg::PH_HEADER, sfd_pkg::PH_DATA, sfd_pkg::PH_CHECK}) begin
          push_o                = 1'b1;
          push_data_o.frame_end = 1'b1;
          push_data_o.status    = sfd_pkg::ST_TIMEOUT;
        end
        phase_d = sfd_pkg::PH_HUNT1;
      end else begin
        case (phase_q)
          sfd_pkg::PH_HUNT1: begin
            if (b == sync_first_q) phase_d = sfd_pkg::PH_HUNT2;
          end
          sfd_pkg::PH_HUNT2: begin
            if (b == sync_second_q) begin
              phase_d = sfd_pkg::PH_HEADER;
              idx_d   = '0;
              sum_d   = '0;
            end else if (b != sync_first_q) begin
              phase_d = sfd_pkg::PH_HUNT1;
            end
          end
          sfd_pkg::PH_HEADER: begin
            if (idx_q < HDR_ID_IDX) begin
              idx_d = idx_inc;
            end else begin
              sum_d                 = sum_add;
              push_o                = 1'b1;
              push_data_o.data_byte = b;
              if (idx_q == HDR_ID_IDX) begin
                idx_d = HDR_LHI_IDX;
              end else if (idx_q == HDR_LHI_IDX) begin
                len_hi_d = b;
                idx_d    = HDR_LLO_IDX;
              end else if (len_bad) begin
                // report the bad length in place of the low length byte
                push_data_o.data_byte = '0;
                push_data_o.frame_end = 1'b1;
                push_data_o.status    = sfd_pkg::ST_BADLEN;
                phase_d               = sfd_pkg::PH_HUNT1;
              end else begin
                idx_d   = '0;
                cnt_d   = sfd_pkg::IDX_W'(len_full - 16'd2);
                phase_d = (len_full == 16'd2) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_DATA;
              end
            end
          end
          sfd_pkg::PH_DATA: begin
            sum_d                 = sum_add;
            push_o                = 1'b1;
            push_data_o.data_byte = b;
            if (idx_inc >= cnt_q) begin
              idx_d   = '0;
              phase_d = sfd_pkg::PH_CHECK;
            end else begin
              idx_d = idx_inc;
            end
          end
          sfd_pkg::PH_CHECK: begin
            if (idx_q == '0) begin
              csum_hi_d = b;
              idx_d     = sfd_pkg::IDX_W'(1);
            end else begin
              push_o                = 1'b1;
              push_data_o.frame_end = 1'b1;
              push_data_o.status    = ({csum_hi_q, b} == sum_q) ? sfd_pkg::ST_OK
                                                                : sfd_pkg::ST_BADSUM;
              phase_d               = sfd_pkg::PH_HUNT1;
            end
          end
          default: phase_d = sfd_pkg::PH_HUNT1;
        endcase
      end
    end
  end

endmodule

@@ hw/rtl/sfd_fifo.sv @@
// Short result queue between the parser and the output stage.
// Depends on sfd_pkg for the result beat type.
module sfd_fifo #(
  parameter int unsigned Depth = sfd_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfd_pkg::result_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sfd_pkg::result_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  sfd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ hw/rtl/sfd_back.sv @@
// Back end: output register that drains the result queue onto the out channel.
// Depends on sfd_pkg and sfd_out_if.
module sfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  sfd_pkg::result_t data_i,
  output logic             pop_o,
  sfd_out_if.source        out_ch
);

  logic             vld_q, vld_d;
  sfd_pkg::result_t res_q;

  // refill whenever the register is empty or its beat leaves this cycle
  assign pop_o = !empty_i && (!vld_q || out_ch.ready);
  assign vld_d = pop_o || (vld_q && !out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= data_i;
  end

  assign out_ch.valid     = vld_q;
  assign out_ch.data_byte = res_q.data_byte;
  assign out_ch.frame_end = res_q.frame_end;
  assign out_ch.status    = res_q.status;

endmodule

@@ hw/rtl/sensor_packet_deframer.sv @@
// Sensor packet deframer top: parser front end, result queue, output register.
// Path: a result beat is written into the queue when its input beat is taken, then moves
// into the output register, from which it is valid on out_ch.
// Throughput: one input byte per cycle; the queue of FifoDepth beats plus the output
// register absorbs output stalls, and in_ch.ready drops only when the queue is full.
// Reset: parser hunts for the first sync byte, queue and output empty, config at defaults.
module sensor_packet_deframer #(
  parameter int unsigned FifoDepth = sfd_pkg::FIFO_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfd_in_if.sink                         in_ch,
  sfd_out_if.source                      out_ch
);

  logic             push, pop, full, empty;
  sfd_pkg::result_t push_data, pop_data;

  sfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (in_ch),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sfd_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  sfd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (pop_data),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("result pushed into full queue");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_ch.valid && empty) |=> !out_ch.valid)
    else $error("output beat without queued result");

  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.frame_end) |-> (out_ch.data_byte == 8'd0))
    else $error("status beat carries data");

  a_payload_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.frame_end) |-> (out_ch.status == sfd_pkg::ST_OK))
    else $error("payload beat carries status");

endmodule
